FILE: sv/smp_pkg.sv
package smp_pkg;

    localparam int STATION_COUNT_DEF = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam int KIND_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int MASK_W    = 32;
    localparam int SIDX_W    = 5;
    localparam int STATUS_W  = 5;
    localparam int PERIOD_W  = 9;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 24;

    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RX_BYTE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_WATER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD_LID  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

    localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST = 9'd5;
    localparam logic [PERIOD_W-1:0] POLL_PERIOD_MIN = 9'd1;
    localparam logic [PERIOD_W-1:0] POLL_PERIOD_MAX = 9'd256;

    localparam logic [BYTE_W-1:0] RX_MARK_BIT = 8'h80;
    localparam logic [BYTE_W-1:0] RX_ST_MASK  = 8'h1F;

    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_TICK        = 3'd1,
        OP_RX          = 3'd2,
        OP_LOAD_WATER  = 3'd3,
        OP_LOAD_LID    = 3'd4,
        OP_READ        = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_STATUS = 3'b010,
        PH_ECHO   = 3'b100
    } t_phase;

    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  rx_byte;
        logic [MASK_W-1:0]  mask;
        logic [SIDX_W-1:0]  idx;
        logic               idx_in_range;
    } t_cmd;

endpackage

FILE: sv/smp_front.sv
module smp_front
    import smp_pkg::*;
#(
    parameter int STATION_COUNT = STATION_COUNT_DEF
) (
    input  logic                i_valid,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [S_DATA_W-1:0] i_data,
    input  logic                i_full,
    output logic                o_ready,
    output logic                o_push,
    output t_cmd                o_cmd
);

    t_op op;

    always_comb begin
        unique case (i_kind)
            KIND_TICK:       op = OP_TICK;
            KIND_RX_BYTE:    op = OP_RX;
            KIND_LOAD_WATER: op = OP_LOAD_WATER;
            KIND_LOAD_LID:   op = OP_LOAD_LID;
            KIND_READ:       op = OP_READ;
            default:         op = OP_NONE;
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.op           = op;
        o_cmd.rx_byte      = i_data[BYTE_W-1:0];
        o_cmd.mask         = i_data[BYTE_W +: MASK_W];
        o_cmd.idx          = i_data[BYTE_W+MASK_W +: SIDX_W];
        o_cmd.idx_in_range = ({1'b0, o_cmd.idx} < (SIDX_W+1)'(STATION_COUNT));
    end

endmodule

FILE: sv/smp_queue.sv
module smp_queue
    import smp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/smp_back.sv
module smp_back
    import smp_pkg::*;
#(
    parameter int STATION_COUNT = STATION_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
    localparam logic [IDX_W-1:0] ST_LAST = IDX_W'(STATION_COUNT - 1);

    logic [PERIOD_W-1:0]      r_poll_period;
    logic [7:0]               r_prescale, n_prescale;
    logic [IDX_W-1:0]         r_station, n_station;
    t_phase                   r_phase, n_phase;
    logic [STATION_COUNT-1:0] r_responded, n_responded;
    logic [STATION_COUNT-1:0] r_water_en, n_water_en;
    logic [STATION_COUNT-1:0] r_lid_en, n_lid_en;
    logic [STATUS_W-1:0]      r_status [STATION_COUNT];
    logic                     status_we;
    logic                     r_out_valid;
    logic [M_DATA_W-1:0]      r_out_data, n_out_data;

    logic [PERIOD_W-1:0]      period;
    logic [PERIOD_W-1:0]      prescale_inc;
    logic                     fire;
    logic                     wrap;
    logic [IDX_W-1:0]         next_st;
    logic [IDX_W-1:0]         rd_st;
    logic [BYTE_W-1:0]        poll_byte;
    logic                     echo_ok;

    assign o_pop = i_cmd_valid && (!r_out_valid || i_m_tready);

    always_comb begin
        if (r_poll_period == '0) begin
            period = POLL_PERIOD_MIN;
        end else if (r_poll_period > POLL_PERIOD_MAX) begin
            period = POLL_PERIOD_MAX;
        end else begin
            period = r_poll_period;
        end
        prescale_inc = {1'b0, r_prescale} + 1'b1;
        fire         = (prescale_inc >= period);
        wrap         = (r_station >= ST_LAST);
        next_st      = wrap ? '0 : r_station + 1'b1;
        poll_byte    = RX_MARK_BIT | {1'b0, r_water_en[next_st], r_lid_en[next_st],
                                      SIDX_W'(next_st)};
        echo_ok      = ((i_cmd.rx_byte & RX_ST_MASK) == BYTE_W'(r_station))
                       && ((i_cmd.rx_byte & RX_MARK_BIT) != '0);
        rd_st        = i_cmd.idx[IDX_W-1:0];
    end

    always_comb begin
        n_prescale  = r_prescale;
        n_station   = r_station;
        n_phase     = r_phase;
        n_responded = r_responded;
        n_water_en  = r_water_en;
        n_lid_en    = r_lid_en;
        status_we   = 1'b0;
        n_out_data  = '0;
        unique case (i_cmd.op)
            OP_TICK: begin
                if (fire) begin
                    n_prescale     = '0;
                    n_station      = next_st;
                    n_phase        = PH_ECHO;
                    n_out_data[0]  = 1'b1;
                    n_out_data[8:1] = poll_byte;
                    n_out_data[9]  = wrap;
                end else begin
                    n_prescale = prescale_inc[7:0];
                end
            end
            OP_RX: begin
                unique case (r_phase)
                    PH_ECHO: begin
                        if (echo_ok) begin
                            n_responded[r_station] = 1'b1;
                            n_phase                = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        status_we     = 1'b1;
                        n_phase       = PH_IDLE;
                        n_out_data[9] = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_LOAD_WATER: n_water_en = i_cmd.mask[STATION_COUNT-1:0];
            OP_LOAD_LID:   n_lid_en   = i_cmd.mask[STATION_COUNT-1:0];
            OP_READ: begin
                if (i_cmd.idx_in_range) begin
                    n_out_data[10]    = r_responded[rd_st];
                    n_out_data[15:11] = r_status[rd_st];
                    n_out_data[16]    = r_water_en[rd_st];
                    n_out_data[17]    = r_lid_en[rd_st];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_period <= POLL_PERIOD_RST;
            r_prescale    <= '0;
            r_station     <= ST_LAST;
            r_phase       <= PH_IDLE;
            r_responded   <= '0;
            r_water_en    <= '0;
            r_lid_en      <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < STATION_COUNT; i++) begin
                r_status[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_poll_period <= i_cfg_data;
            end
            if (o_pop) begin
                r_prescale  <= n_prescale;
                r_station   <= n_station;
                r_phase     <= n_phase;
                r_responded <= n_responded;
                r_water_en  <= n_water_en;
                r_lid_en    <= n_lid_en;
                if (status_we) begin
                    r_status[r_station] <= i_cmd.rx_byte[STATUS_W-1:0];
                end
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: sv/station_polling_master.sv
// channel   direction  handshake                      payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata, tuser (kind)
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata
// cfg       in         i_cfg_valid/o_cfg_ready         poll period
//
// one word in, one word out; a word is registered in the queue, then in the output register
// (classify into a two-deep queue, execute into the output register)
// sustained rate one word per cycle while the output is not stalled, set by the execute stage
// synchronous active-low reset clears all tables, poll period back to 5
// output stall backs up into the queue, input tready drops when it is full
module station_polling_master
    import smp_pkg::*;
#(
    parameter int STATION_COUNT = STATION_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,  // rx_byte, enable_mask, station_index
    input  logic [KIND_W-1:0]   i_s_axis_tuser,  // kind
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tx_valid, tx_byte, refresh, rd_responded, rd_lid_open, rd_water, rd_lid_alarm,
    // rd_water_alarm, rd_general_alarm, rd_enable_water, rd_enable_lid
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    logic q_full, q_push, q_valid, q_pop;
    t_cmd front_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;

    smp_front #(
        .STATION_COUNT(STATION_COUNT)
    ) u_front (
        .i_valid (i_s_axis_tvalid),
        .i_kind  (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .i_full  (q_full),
        .o_ready (o_s_axis_tready),
        .o_push  (q_push),
        .o_cmd   (front_cmd)
    );

    smp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    smp_back #(
        .STATION_COUNT(STATION_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (q_pop),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata)
    );

    // full queue only while an output word is held
    a_full_means_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> o_m_axis_tvalid)
        else $error("queue full without output word held");

    // no poll byte unless a poll is sent
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[8:1] == '0))
        else $error("tx_byte set without tx_valid");

    // a poll word always carries the mark bit and never carries read-back bits
    a_poll_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |->
        (o_m_axis_tdata[8] && (o_m_axis_tdata[17:10] == '0)))
        else $error("malformed poll word");

    // pop only with data in the queue
    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

FILE: bench/station_polling_master_checker.sv
module station_polling_master_checker
    import smp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    input  logic                i_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    input  logic [KIND_W-1:0]   i_s_axis_tuser,
    input  logic                i_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    input  logic [M_DATA_W-1:0] i_m_axis_tdata,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    output int                  o_error_count,
    output int                  o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATIONS = STATION_COUNT_DEF;

    // last field in the lowest bit
    typedef struct packed {
        logic              rd_enable_lid;
        logic              rd_enable_water;
        logic              rd_general_alarm;
        logic              rd_water_alarm;
        logic              rd_lid_alarm;
        logic              rd_water;
        logic              rd_lid_open;
        logic              rd_responded;
        logic              refresh;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
    } t_station_reply;

    logic [PERIOD_W-1:0] poll_period;
    logic [7:0]          prescale;
    logic [SIDX_W-1:0]   cur_station;
    t_phase              rx_phase;
    logic [STATIONS-1:0] responded;
    logic [STATUS_W-1:0] status_tab [STATIONS];
    logic [STATIONS-1:0] water_en;
    logic [STATIONS-1:0] lid_en;

    t_station_reply awaited_replies [$];
    t_station_reply got_reply;
    t_station_reply want_reply;
    int             errors = 0;

    function automatic t_station_reply advance_station_model(
        input logic [KIND_W-1:0] kind,
        input logic [BYTE_W-1:0] rx,
        input logic [MASK_W-1:0] mask,
        input logic [SIDX_W-1:0] idx
    );
        t_station_reply r;
        int             period;
        r = '0;
        case (kind)
            KIND_TICK: begin
                if (poll_period == '0)
                    period = 1;
                else if (poll_period > POLL_PERIOD_MAX)
                    period = int'(POLL_PERIOD_MAX);
                else
                    period = int'(poll_period);
                if (int'(prescale) + 1 >= period) begin
                    prescale = '0;
                    // wrap ends a polling round
                    if (int'(cur_station) >= STATIONS - 1) begin
                        cur_station = '0;
                        r.refresh   = 1'b1;
                    end else begin
                        cur_station = cur_station + 1'b1;
                    end
                    r.tx_valid = 1'b1;
                    r.tx_byte  = RX_MARK_BIT | {1'b0, water_en[cur_station],
                                                lid_en[cur_station], cur_station};
                    rx_phase   = PH_ECHO;
                end else begin
                    prescale = prescale + 1'b1;
                end
            end
            KIND_RX_BYTE: begin
                if (rx_phase == PH_ECHO) begin
                    if ((rx & RX_ST_MASK) == {3'b000, cur_station} &&
                        (rx & RX_MARK_BIT) != '0) begin
                        responded[cur_station] = 1'b1;
                        rx_phase = PH_STATUS;
                    end
                end else if (rx_phase == PH_STATUS) begin
                    status_tab[cur_station] = rx[STATUS_W-1:0];
                    rx_phase  = PH_IDLE;
                    r.refresh = 1'b1;
                end
            end
            KIND_LOAD_WATER: water_en = mask[STATIONS-1:0];
            KIND_LOAD_LID:   lid_en   = mask[STATIONS-1:0];
            KIND_READ: begin
                r.rd_responded = responded[idx];
                {r.rd_general_alarm, r.rd_water_alarm, r.rd_lid_alarm,
                 r.rd_water, r.rd_lid_open} = status_tab[idx];
                r.rd_enable_water = water_en[idx];
                r.rd_enable_lid   = lid_en[idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string field_name, input int want, input int got);
        if (want != got) begin
            if (errors < 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $realtime, field_name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poll_period = POLL_PERIOD_RST;
            prescale    = '0;
            cur_station = SIDX_W'(STATIONS - 1);
            rx_phase    = PH_IDLE;
            responded   = '0;
            water_en    = '0;
            lid_en      = '0;
            for (int i = 0; i < STATIONS; i++)
                status_tab[i] = '0;
            awaited_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                poll_period = i_cfg_data;
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_reply = t_station_reply'(i_m_axis_tdata[$bits(t_station_reply)-1:0]);
                if (awaited_replies.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result word with none outstanding, got 0x%0h",
                                 $realtime, got_reply);
                    errors++;
                end else begin
                    want_reply = awaited_replies.pop_front();
                    check_field("tx_valid", want_reply.tx_valid, got_reply.tx_valid);
                    check_field("tx_byte", want_reply.tx_byte, got_reply.tx_byte);
                    check_field("refresh", want_reply.refresh, got_reply.refresh);
                    check_field("rd_responded", want_reply.rd_responded,
                                got_reply.rd_responded);
                    check_field("rd_lid_open", want_reply.rd_lid_open,
                                got_reply.rd_lid_open);
                    check_field("rd_water", want_reply.rd_water, got_reply.rd_water);
                    check_field("rd_lid_alarm", want_reply.rd_lid_alarm,
                                got_reply.rd_lid_alarm);
                    check_field("rd_water_alarm", want_reply.rd_water_alarm,
                                got_reply.rd_water_alarm);
                    check_field("rd_general_alarm", want_reply.rd_general_alarm,
                                got_reply.rd_general_alarm);
                    check_field("rd_enable_water", want_reply.rd_enable_water,
                                got_reply.rd_enable_water);
                    check_field("rd_enable_lid", want_reply.rd_enable_lid,
                                got_reply.rd_enable_lid);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                awaited_replies.push_back(advance_station_model(i_s_axis_tuser,
                    i_s_axis_tdata[7:0], i_s_axis_tdata[39:8], i_s_axis_tdata[44:40]));
        end
        o_error_count   <= errors;
        o_pending_count <= awaited_replies.size();
    end

endmodule

FILE: bench/station_polling_master_tb.sv
module station_polling_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data  = '0;

    int          errors;
    int          pending;
    bit          steady         = 1'b0;
    int          eff_period     = 5;
    logic [4:0]  polled_station = 5'd31;

    station_polling_master u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    station_polling_master_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_error_count   (errors),
        .o_pending_count (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(99) >= 6);
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] rx,
                             input logic [31:0] mask, input logic [4:0] idx);
        while (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, idx, mask, rx};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
    endtask

    // each run of eff_period ticks gives exactly one poll
    task automatic tick_poll(input int polls);
        repeat (polls * eff_period)
            send_item(KIND_TICK, 8'($urandom), $urandom, 5'($urandom));
        polled_station = polled_station + 5'(polls);
    endtask

    task automatic send_echo();
        send_item(KIND_RX_BYTE, {1'b1, 2'($urandom), polled_station}, $urandom,
                  5'($urandom));
    endtask

    task automatic send_noise();
        logic [KIND_W-1:0] kind;
        logic [31:0]       mask;
        int                pick;
        kind = KIND_W'($urandom_range(int'(KIND_RX_BYTE), int'(KIND_UNUSED_HI)));
        pick = $urandom_range(7);
        mask = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        send_item(kind, 8'($urandom), mask, 5'($urandom));
    endtask

    task automatic write_poll_period(input logic [PERIOD_W-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value == '0)
            eff_period = 1;
        else if (value > POLL_PERIOD_MAX)
            eff_period = int'(POLL_PERIOD_MAX);
        else
            eff_period = int'(value);
    endtask

    task automatic run_poll_round(input bit well_formed);
        int choice;
        repeat ($urandom_range(2))
            send_noise();
        if (well_formed) begin
            tick_poll(1);
            send_echo();
            send_item(KIND_RX_BYTE, 8'($urandom), $urandom, 5'($urandom));
            send_item(KIND_READ, 8'($urandom), $urandom,
                      $urandom_range(1) ? polled_station : 5'($urandom));
        end else begin
            choice = $urandom_range(3);
            case (choice)
                0: begin
                    // garbage instead of the echo
                    tick_poll(1);
                    send_item(KIND_RX_BYTE, 8'($urandom), $urandom, 5'($urandom));
                    send_item(KIND_RX_BYTE, 8'($urandom), $urandom, 5'($urandom));
                end
                1: begin
                    // next poll cuts in before the status word
                    tick_poll(1);
                    send_echo();
                    tick_poll(1);
                    send_item(KIND_RX_BYTE, 8'($urandom), $urandom, 5'($urandom));
                end
                2: begin
                    tick_poll($urandom_range(2, 3));
                    send_echo();
                end
                default: begin
                    send_echo();
                    send_item(KIND_RX_BYTE, 8'($urandom), $urandom, 5'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset poll period
        send_item(KIND_READ, 8'h00, 32'h0, 5'd0);
        send_item(KIND_READ, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_item(KIND_RX_BYTE, 8'h80, 32'h0, 5'd0);
        send_item(KIND_LOAD_WATER, 8'h00, 32'hFFFF_FFFF, 5'd0);
        send_item(KIND_LOAD_LID, 8'h00, 32'h5555_5555, 5'd0);
        send_item(KIND_UNUSED_LO, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_item(KIND_UNUSED_HI, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        tick_poll(1);
        send_item(KIND_RX_BYTE, 8'h00, 32'h0, 5'd0);
        send_item(KIND_RX_BYTE, 8'h81, 32'h0, 5'd0);
        send_item(KIND_RX_BYTE, 8'h80, 32'h0, 5'd0);
        send_item(KIND_RX_BYTE, 8'hFF, 32'h0, 5'd0);
        send_item(KIND_READ, 8'h00, 32'h0, 5'd0);
        send_item(KIND_LOAD_WATER, 8'hFF, 32'h0, 5'd0);
        send_item(KIND_LOAD_LID, 8'hFF, 32'h0, 5'd0);
        send_item(KIND_READ, 8'h00, 32'h0, 5'd0);

        write_poll_period(9'd0);
        repeat (10)
            run_poll_round($urandom_range(99) < 80);

        write_poll_period(POLL_PERIOD_MIN);
        repeat (10)
            run_poll_round($urandom_range(99) < 80);

        // no idling on either side
        write_poll_period(9'd3);
        steady = 1'b1;
        repeat (12)
            run_poll_round($urandom_range(99) < 80);
        steady = 1'b0;

        write_poll_period(PERIOD_W'($urandom_range(2, 9)));
        repeat (8)
            run_poll_round($urandom_range(99) < 80);

        write_poll_period(POLL_PERIOD_MAX);
        repeat (10)
            send_noise();

        write_poll_period(9'h1FF);
        run_poll_round(1'b1);

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
